// File: hdl/rnsc_pkg.sv
// ----------------------------------------------------------------------------
// rnsc_pkg
// Types, sizes and helper functions shared by the node split chooser.
// ----------------------------------------------------------------------------
package rnsc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CAP         = MAX_ENTRIES + 1;
    localparam int IW          = $clog2(CAP);
    localparam int CW          = $clog2(CAP + 1);
    localparam int MARGIN_W    = 19;
    localparam int MSUM_W      = MARGIN_W + $clog2(CAP);
    localparam int OV_W        = 34;
    localparam int AR_W        = 35;
    localparam logic [3:0] MIN_GROUP_RST = 4'd6;

    typedef struct packed {
        logic signed [15:0] x_low;
        logic signed [15:0] x_high;
        logic signed [15:0] y_low;
        logic signed [15:0] y_high;
    } t_rect;

    typedef struct packed {
        logic signed [15:0] x_low;
        logic signed [15:0] x_high;
        logic signed [15:0] y_low;
        logic signed [15:0] y_high;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [5:0] entry_index;
        logic       group;
        logic       split_axis;
        logic       final_res;
    } t_out;

    typedef enum logic [3:0] {
        ST_LOAD, ST_START, ST_RK_LD, ST_RK_CMP, ST_RK_WR, ST_PRE, ST_SUF,
        ST_EV_A, ST_EV_B, ST_AXIS, ST_MARK, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic rk_ld;
        logic rk_cmp;
        logic rk_wr;
        logic pre;
        logic suf;
        logic ev_a;
        logic ev_b;
        logic axis;
        logic mark;
        logic out_step;
    } t_cmd;

    typedef struct packed {
        logic single;
        logic j_end;
        logic i_end;
        logic p_end;
        logic p_zero;
        logic s_end;
        logic pass_final;
        logic out_free;
    } t_stat;

    function automatic t_rect box_merge(t_rect a, t_rect b);
        t_rect r;
        r.x_low  = (a.x_low  < b.x_low)  ? a.x_low  : b.x_low;
        r.x_high = (a.x_high > b.x_high) ? a.x_high : b.x_high;
        r.y_low  = (a.y_low  < b.y_low)  ? a.y_low  : b.y_low;
        r.y_high = (a.y_high > b.y_high) ? a.y_high : b.y_high;
        return r;
    endfunction

    function automatic logic signed [16:0] diff17(logic signed [15:0] hi,
                                                  logic signed [15:0] lo);
        return {hi[15], hi} - {lo[15], lo};
    endfunction

endpackage

// File: hdl/rnsc_ctrl.sv
// ----------------------------------------------------------------------------
// rnsc_ctrl
// Sequencer for loading, ranking, box sweeps, split scan, group marking and result output.
// ----------------------------------------------------------------------------
module rnsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  rnsc_pkg::t_stat i_stat,
    output logic          o_in_stall,
    output rnsc_pkg::t_cmd  o_cmd
);
    import rnsc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:   if (i_in_valid && i_in_last) n_state = ST_START;
            ST_START:  n_state = i_stat.single ? ST_OUT : ST_RK_LD;
            ST_RK_LD:  n_state = ST_RK_CMP;
            ST_RK_CMP: if (i_stat.j_end) n_state = ST_RK_WR;
            ST_RK_WR:  n_state = i_stat.i_end ? ST_PRE : ST_RK_LD;
            ST_PRE:    if (i_stat.p_end) n_state = ST_SUF;
            ST_SUF:    if (i_stat.p_zero) n_state = ST_EV_A;
            ST_EV_A:   n_state = ST_EV_B;
            ST_EV_B:   n_state = i_stat.s_end ? ST_AXIS : ST_EV_A;
            ST_AXIS:   n_state = i_stat.pass_final ? ST_MARK : ST_RK_LD;
            ST_MARK:   if (i_stat.p_end) n_state = ST_OUT;
            ST_OUT:    if (i_stat.out_free && i_stat.i_end) n_state = ST_LOAD;
            default:   n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_START:  o_cmd.start  = 1'b1;
            ST_RK_LD:  o_cmd.rk_ld  = 1'b1;
            ST_RK_CMP: o_cmd.rk_cmp = 1'b1;
            ST_RK_WR:  o_cmd.rk_wr  = 1'b1;
            ST_PRE:    o_cmd.pre    = 1'b1;
            ST_SUF:    o_cmd.suf    = 1'b1;
            ST_EV_A:   o_cmd.ev_a   = 1'b1;
            ST_EV_B:   o_cmd.ev_b   = 1'b1;
            ST_AXIS:   o_cmd.axis   = 1'b1;
            ST_MARK:   o_cmd.mark   = 1'b1;
            ST_OUT:    o_cmd.out_step = i_stat.out_free;
            default:   o_in_stall   = 1'b1;
        endcase
    end

endmodule

// File: hdl/rnsc_dpath.sv
// ----------------------------------------------------------------------------
// rnsc_dpath
// Entry store, rank counter, prefix and suffix boxes, split metrics, output
// register.
// ----------------------------------------------------------------------------
module rnsc_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rnsc_pkg::t_cmd i_cmd,
    input  rnsc_pkg::t_in  i_in_data,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_data,
    input  logic           i_out_stall,
    output rnsc_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output rnsc_pkg::t_out o_out_data
);
    import rnsc_pkg::*;

    logic [3:0]    r_min_group;
    t_rect         r_rect [CAP];
    t_rect         r_pre  [CAP];
    t_rect         r_suf  [CAP];
    logic [IW-1:0] r_ord  [CAP];
    logic [CAP-1:0] r_grp;
    logic [CW-1:0] r_cnt, r_n, r_m;
    logic [IW-1:0] r_i, r_j, r_p, r_s, r_rank, r_split;
    t_rect         r_ri, r_acc;
    logic [1:0]    r_pass;
    logic          r_axis;
    logic signed [MSUM_W-1:0]   r_msum, r_best_sum;
    logic signed [MARGIN_W-1:0] r_mg;
    logic signed [OV_W-1:0]     r_ov, r_best_ov;
    logic signed [AR_W-1:0]     r_ar, r_best_ar;
    logic          r_ovalid;
    t_out          r_odata;

    logic [IW-1:0] rd_addr;
    t_rect         rd_rect, box_pre, box_suf, pa, sb;
    logic          cur_axis, less;
    logic signed [15:0] lj, hj, li, hi;
    logic [CW-1:0] n_last, half, m_new, cnt_inc;
    logic signed [15:0] lox, hix, loy, hiy;
    logic signed [16:0] dx, dy, ax, ay, bx, by;
    logic signed [OV_W-1:0] ov_new;
    logic signed [AR_W-1:0] ar_new;
    logic signed [MARGIN_W-1:0] mg_new;
    logic          better;

    assign n_last  = r_n - CW'(1);
    assign cnt_inc = r_cnt + CW'(1);
    assign cur_axis = (r_pass == 2'd0) ? 1'b0 : (r_pass == 2'd1) ? 1'b1 : r_axis;

    always_comb begin
        if (i_cmd.rk_ld) begin
            rd_addr = r_i;
        end else if (i_cmd.rk_cmp) begin
            rd_addr = r_j;
        end else begin
            rd_addr = r_ord[r_p];
        end
    end
    assign rd_rect = r_rect[rd_addr];

    // Sort key: low edge, then high edge, then arrival index.
    always_comb begin
        lj = cur_axis ? rd_rect.y_low  : rd_rect.x_low;
        hj = cur_axis ? rd_rect.y_high : rd_rect.x_high;
        li = cur_axis ? r_ri.y_low     : r_ri.x_low;
        hi = cur_axis ? r_ri.y_high    : r_ri.x_high;
        less = (lj < li) || (lj == li && hj < hi) || (lj == li && hj == hi && r_j < r_i);
    end

    assign box_pre = (r_p == '0) ? rd_rect : box_merge(r_acc, rd_rect);
    assign box_suf = (r_p == n_last[IW-1:0]) ? rd_rect : box_merge(r_acc, rd_rect);

    always_comb begin
        half  = r_n >> 1;
        m_new = (r_min_group == 4'd0) ? CW'(1) : CW'(r_min_group);
        if (m_new > half) begin
            m_new = half;
        end
    end

    // Split metrics for the current split point.
    always_comb begin
        pa  = r_pre[r_s - IW'(1)];
        sb  = r_suf[r_s];
        lox = (pa.x_low  > sb.x_low)  ? pa.x_low  : sb.x_low;
        hix = (pa.x_high < sb.x_high) ? pa.x_high : sb.x_high;
        loy = (pa.y_low  > sb.y_low)  ? pa.y_low  : sb.y_low;
        hiy = (pa.y_high < sb.y_high) ? pa.y_high : sb.y_high;
        dx  = diff17(hix, lox);
        dy  = diff17(hiy, loy);
        ax  = diff17(pa.x_high, pa.x_low);
        ay  = diff17(pa.y_high, pa.y_low);
        bx  = diff17(sb.x_high, sb.x_low);
        by  = diff17(sb.y_high, sb.y_low);
        ov_new = (dx > 17'sd0 && dy > 17'sd0) ? dx * dy : '0;
        ar_new = AR_W'(ax * ay) + AR_W'(bx * by);
        mg_new = MARGIN_W'(ax) + MARGIN_W'(ay) + MARGIN_W'(bx) + MARGIN_W'(by);
        better = (r_s == r_m[IW-1:0]) || (r_ov < r_best_ov)
              || (r_ov == r_best_ov && r_ar < r_best_ar);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_group <= MIN_GROUP_RST;
            r_cnt       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_group <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (r_cnt < CW'(CAP)) begin
                    r_rect[r_cnt[IW-1:0]] <= t_rect'(i_in_data[64:1]);
                end
                if (i_in_data.last) begin
                    r_n   <= (r_cnt < CW'(CAP)) ? cnt_inc : r_cnt;
                    r_cnt <= '0;
                end else if (r_cnt < CW'(CAP)) begin
                    r_cnt <= cnt_inc;
                end
            end
            if (i_cmd.out_step) begin
                r_ovalid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_m    <= m_new;
            r_pass <= 2'd0;
            r_axis <= 1'b0;
            r_i    <= '0;
            r_grp  <= '0;
        end
        if (i_cmd.rk_ld) begin
            r_ri   <= rd_rect;
            r_j    <= '0;
            r_rank <= '0;
        end
        if (i_cmd.rk_cmp) begin
            if (less) begin
                r_rank <= r_rank + IW'(1);
            end
            r_j <= r_j + IW'(1);
        end
        if (i_cmd.rk_wr) begin
            r_ord[r_rank] <= r_i;
            if (o_stat.i_end) begin
                r_p <= '0;
            end else begin
                r_i <= r_i + IW'(1);
            end
        end
        if (i_cmd.pre) begin
            r_pre[r_p] <= box_pre;
            r_acc      <= box_pre;
            if (!o_stat.p_end) begin
                r_p <= r_p + IW'(1);
            end
        end
        if (i_cmd.suf) begin
            r_suf[r_p] <= box_suf;
            r_acc      <= box_suf;
            if (o_stat.p_zero) begin
                r_s    <= r_m[IW-1:0];
                r_msum <= '0;
            end else begin
                r_p <= r_p - IW'(1);
            end
        end
        if (i_cmd.ev_a) begin
            r_mg <= mg_new;
            r_ov <= ov_new;
            r_ar <= ar_new;
        end
        if (i_cmd.ev_b) begin
            if (!o_stat.pass_final) begin
                r_msum <= r_msum + MSUM_W'(r_mg);
            end else if (better) begin
                r_best_ov <= r_ov;
                r_best_ar <= r_ar;
                r_split   <= r_s;
            end
            if (!o_stat.s_end) begin
                r_s <= r_s + IW'(1);
            end
        end
        if (i_cmd.axis) begin
            r_i <= '0;
            if (r_pass == 2'd0) begin
                r_best_sum <= r_msum;
                r_pass     <= 2'd1;
            end else if (r_pass == 2'd1) begin
                // The later axis wins a tie.
                if (r_msum <= r_best_sum) begin
                    r_axis <= 1'b1;
                end
                r_pass <= 2'd2;
            end else begin
                r_p <= r_split;
            end
        end
        if (i_cmd.mark) begin
            r_grp[r_ord[r_p]] <= 1'b1;
            if (!o_stat.p_end) begin
                r_p <= r_p + IW'(1);
            end
        end
        if (i_cmd.out_step) begin
            r_odata.entry_index <= 6'(r_i);
            r_odata.group       <= r_grp[r_i];
            r_odata.split_axis  <= r_axis;
            r_odata.final_res   <= o_stat.i_end;
            r_i                 <= r_i + IW'(1);
        end
    end

    always_comb begin
        o_stat.single     = (r_n == CW'(1));
        o_stat.j_end      = (r_j == n_last[IW-1:0]);
        o_stat.i_end      = (r_i == n_last[IW-1:0]);
        o_stat.p_end      = (r_p == n_last[IW-1:0]);
        o_stat.p_zero     = (r_p == '0);
        o_stat.s_end      = (CW'(r_s) == r_n - r_m);
        o_stat.pass_final = (r_pass == 2'd2);
        o_stat.out_free   = !r_ovalid || !i_out_stall;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

// File: hdl/rstar_node_split_chooser.sv
// ----------------------------------------------------------------------------
// rstar_node_split_chooser
// R*-tree topological split of one overflowing node of 2-D rectangles.
// ----------------------------------------------------------------------------
// Input channel: one rectangle per word, up to 17 per node, the word with
// last set closes the node. Words beyond 17 are dropped but their last flag
// still closes the node. Loading takes one word per cycle.
// After last the block stalls its input and works on the node. Each of three
// passes (first axis, second axis, chosen axis) ranks the entries with one
// key compare per cycle, sweeps prefix and suffix boxes and scans the split
// points, each through states EV_A and EV_B. A node of one entry skips these
// passes. Then the upper group is marked and one result word per entry leaves
// in arrival order, one per cycle while the receiver does not stall.
// The result register holds a word while the receiver stalls; the input
// opens again as soon as the final word is in that register.
// Reset empties the node, drops any pending result and sets min_group to 6.
// ----------------------------------------------------------------------------
module rstar_node_split_chooser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rnsc_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output rnsc_pkg::t_out o_out_data,
    input  logic           i_out_stall,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_data
);
    import rnsc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rnsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    rnsc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hdl/rnsc_checker.sv
// ----------------------------------------------------------------------------
// rnsc_checker
// Port-level checks of the node split chooser, bound to the top level.
// ----------------------------------------------------------------------------
module rnsc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input rnsc_pkg::t_in  i_in_data,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input rnsc_pkg::t_out o_out_data,
    input logic           i_out_stall
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.last |=> o_in_stall)
        else $error("input open right after the last word");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.final_res |=> !o_out_valid)
        else $error("result word right after the final word");

    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.final_res |=>
        o_out_valid && o_out_data.split_axis == $past(o_out_data.split_axis)
        && o_out_data.entry_index == $past(o_out_data.entry_index) + 6'd1)
        else $error("result words of one node disagree");

endmodule

bind rstar_node_split_chooser rnsc_checker u_rnsc_checker (.*);
